### hw/rtl/hpc_pkg.sv
// Shared types and constants for the hex pixel-to-cell rounding block.
package hpc_pkg;

   // Pixel fraction bits (default for the top-level parameter)
   localparam int FRAC_BITS_DEFAULT = 4;

   // Q16 format of the basis constants, the reciprocal and the cube coordinates
   localparam int Q_BITS = 16;

   // Basis constants, unsigned Q16: 8/sqrt(3), 16/sqrt(3), 8 and 4
   localparam int K_Y_FROM_X = 302698;
   localparam int K_X_FROM_Y = 605396;
   localparam int K_EIGHT    = 524288;
   localparam int K_FOUR     = 262144;

   // Width of the basis sums ay and ax, which stay below 2^35 in magnitude
   localparam int SUM_W = 36;

   // Reciprocal reset value
   localparam logic [15:0] RECIP_RESET = 16'd1024;

   // Cube component order
   localparam int COMP_X = 0;
   localparam int COMP_Y = 1;
   localparam int COMP_Z = 2;

   typedef struct packed {
      logic signed [15:0] pixel_x;
      logic signed [15:0] pixel_y;
   } req_type;

   typedef struct packed {
      logic signed [15:0] cell_x;
      logic signed [15:0] cell_y;
   } rsp_type;

endpackage

### hw/rtl/hpc_cube_round.sv
// Cube rounding stages: round each component, then rebuild the worst one and saturate.
module hpc_cube_round #(
   parameter int GW = 37
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic signed [GW-1:0] comp [3],
   output logic                 out_valid,
   output hpc_pkg::rsp_type     out_data
);
   import hpc_pkg::*;

   // Width of a rounded component, and of the sum of two of them
   localparam int RDW = GW - Q_BITS + 2;
   localparam int SW  = RDW + 1;
   localparam logic signed [SW-1:0] SAT_HI = SW'(32767);
   localparam logic signed [SW-1:0] SAT_LO = -SW'(32768);

   logic [GW:0]            mag [3];
   logic [GW:0]            mag_sum [3];
   logic [Q_BITS-1:0]      frac [3];
   logic signed [RDW-1:0]  rnd_in [3];
   logic [Q_BITS:0]        err_in [3];

   logic signed [RDW-1:0]  rnd_ff [3];
   logic [Q_BITS:0]        err_ff [3];
   logic                   rnd_valid_ff;

   logic signed [SW-1:0]   cx;
   logic signed [SW-1:0]   cy;
   rsp_type                rsp_in;
   rsp_type                rsp_ff;
   logic                   rsp_valid_ff;

   // Round half away from zero and measure the rounding error
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         mag[i]     = comp[i][GW-1] ? (GW+1)'(-comp[i]) : (GW+1)'(comp[i]);
         mag_sum[i] = mag[i] + (GW+1)'(1 << (Q_BITS - 1));
         frac[i]    = mag[i][Q_BITS-1:0];
         rnd_in[i]  = comp[i][GW-1] ? -RDW'($signed({1'b0, mag_sum[i][GW:Q_BITS]}))
                                    :  RDW'($signed({1'b0, mag_sum[i][GW:Q_BITS]}));
         err_in[i]  = frac[i][Q_BITS-1] ? (Q_BITS+1)'((Q_BITS+1)'(1 << Q_BITS) - frac[i])
                                        : {1'b0, frac[i]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rnd_valid_ff <= 1'b0;
      end else begin
         rnd_valid_ff <= in_valid;
      end
      rnd_ff <= rnd_in;
      err_ff <= err_in;
   end

   // Rebuild the component with the largest error from the other two
   always_comb begin
      priority if (err_ff[COMP_X] > err_ff[COMP_Y] && err_ff[COMP_X] > err_ff[COMP_Z]) begin
         cx = -SW'(rnd_ff[COMP_Y]) - SW'(rnd_ff[COMP_Z]);
         cy = SW'(rnd_ff[COMP_Y]);
      end else if (err_ff[COMP_Y] > err_ff[COMP_Z]) begin
         cx = SW'(rnd_ff[COMP_X]);
         cy = -SW'(rnd_ff[COMP_X]) - SW'(rnd_ff[COMP_Z]);
      end else begin
         // z rounded worst, or tied for worst: keep the rounded values
         cx = SW'(rnd_ff[COMP_X]);
         cy = SW'(rnd_ff[COMP_Y]);
      end
      // Saturate to 16 bits
      if (cx > SAT_HI) begin
         rsp_in.cell_x = 16'sh7fff;
      end else if (cx < SAT_LO) begin
         rsp_in.cell_x = -16'sh8000;
      end else begin
         rsp_in.cell_x = cx[15:0];
      end
      if (cy > SAT_HI) begin
         rsp_in.cell_y = 16'sh7fff;
      end else if (cy < SAT_LO) begin
         rsp_in.cell_y = -16'sh8000;
      end else begin
         rsp_in.cell_y = cy[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rnd_valid_ff;
      end
      rsp_ff <= rsp_in;
   end

   assign out_valid = rsp_valid_ff;
   assign out_data  = rsp_ff;

endmodule

### hw/rtl/hex_pixel_to_cell_round.sv
// Top level of the hex pixel-to-cell rounding pipeline.
//
// Maps a pixel position (signed, FRAC_BITS fraction bits) to the axial
// coordinates of the hexagonal cell that contains it.
// Input: drive req_data and raise start; the transfer happens at the rising
// edge where start is high and busy is low. busy stays low, so one pixel
// can be sent in every cycle.
// Output: rsp_valid is high for exactly one cycle with rsp_data; the
// receiver has no way to stall, so it must take the result in that cycle.
// Pipeline: five register stages (basis sums, reciprocal multiply, floor
// shift, cube rounding, reselect and saturate) lie between the input
// transfer and the result.
// Throughput: one item per cycle, fully pipelined.
// Configuration: csr_we with csr_wdata writes the scale reciprocal (Q16);
// write it only while no item is in flight.
// Reset (synchronous, active high) empties the pipeline and sets the
// reciprocal to 1024.
module hex_pixel_to_cell_round #(
   parameter int FRAC_BITS = hpc_pkg::FRAC_BITS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  hpc_pkg::req_type req_data,
   output logic             rsp_valid,
   output hpc_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [15:0]      csr_wdata
);
   import hpc_pkg::*;

   localparam int RW    = 17;
   localparam int PW    = SUM_W + RW;
   localparam int SHIFT = FRAC_BITS + Q_BITS;
   localparam int FW    = PW - SHIFT;
   localparam int GW    = FW + 1;

   logic [15:0]              recip_ff;

   logic signed [SUM_W-1:0]  px_w;
   logic signed [SUM_W-1:0]  py_w;
   logic signed [SUM_W-1:0]  ay_in;
   logic signed [SUM_W-1:0]  ax_in;
   logic signed [SUM_W-1:0]  ay_ff;
   logic signed [SUM_W-1:0]  ax_ff;
   logic                     s1_valid_ff;

   logic signed [RW-1:0]     recip_s;
   logic signed [PW-1:0]     prod_y_in;
   logic signed [PW-1:0]     prod_x_in;
   logic signed [PW-1:0]     prod_y_ff;
   logic signed [PW-1:0]     prod_x_ff;
   logic                     s2_valid_ff;

   logic signed [PW-1:0]     shy;
   logic signed [PW-1:0]     shx;
   logic signed [GW-1:0]     comp_in [3];
   logic signed [GW-1:0]     comp_ff [3];
   logic                     s3_valid_ff;

   logic                     accept;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   // Hold the scale reciprocal
   always_ff @(posedge clock) begin
      if (reset) begin
         recip_ff <= RECIP_RESET;
      end else if (csr_we) begin
         recip_ff <= csr_wdata;
      end
   end

   // Stage 1: basis sums
   always_comb begin
      px_w  = SUM_W'(req_data.pixel_x);
      py_w  = SUM_W'(req_data.pixel_y);
      ay_in = px_w * SUM_W'(K_Y_FROM_X) - py_w * SUM_W'(K_EIGHT);
      ax_in = py_w * SUM_W'(K_X_FROM_Y) - px_w * SUM_W'(K_FOUR);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
      ay_ff <= ay_in;
      ax_ff <= ax_in;
   end

   // Stage 2: multiply by the reciprocal
   always_comb begin
      recip_s   = $signed({1'b0, recip_ff});
      prod_y_in = PW'(ay_ff) * PW'(recip_s);
      prod_x_in = PW'(ax_ff) * PW'(recip_s);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      prod_y_ff <= prod_y_in;
      prod_x_ff <= prod_x_in;
   end

   // Stage 3: floor shift to Q16 and form the third cube component
   always_comb begin
      shy              = prod_y_ff >>> SHIFT;
      shx              = prod_x_ff >>> SHIFT;
      comp_in[COMP_X]  = GW'($signed(shx[FW-1:0]));
      comp_in[COMP_Y]  = GW'($signed(shy[FW-1:0]));
      comp_in[COMP_Z]  = -GW'($signed(shx[FW-1:0])) - GW'($signed(shy[FW-1:0]));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
      end
      comp_ff <= comp_in;
   end

   // Stages 4 and 5: cube rounding and output register
   hpc_cube_round #(
      .GW (GW)
   ) u_round (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s3_valid_ff),
      .comp      (comp_ff),
      .out_valid (rsp_valid),
      .out_data  (rsp_data)
   );

endmodule

### hw/rtl/hpc_checker.sv
// Port-level checker for the hex pixel-to-cell block, with its bind.
module hpc_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input hpc_pkg::req_type req_data,
   input logic             rsp_valid,
   input hpc_pkg::rsp_type rsp_data
);
   import hpc_pkg::*;

   localparam logic [2:0] DEPTH = 3'd5;

   logic [2:0] settle_ff;
   logic       quiet5;

   // Count cycles out of reset, up to the pipeline depth
   always_ff @(posedge clock) begin
      if (reset) begin
         settle_ff <= '0;
      end else if (settle_ff != DEPTH) begin
         settle_ff <= settle_ff + 3'd1;
      end
   end

   assign quiet5 = (settle_ff == DEPTH);

   // One result strobe per transfer, and none without a transfer
   a_latency: assert property (@(posedge clock) disable iff (reset)
      quiet5 |-> (rsp_valid == $past(start && !busy, 5)))
      else $error("result strobe does not follow transfer by five cycles");

   // The origin pixel always maps to the origin cell
   a_origin: assert property (@(posedge clock) disable iff (reset)
      (quiet5 && rsp_valid && $past(start && !busy && req_data == '0, 5))
      |-> (rsp_data == '0))
      else $error("origin pixel did not map to cell zero");

   // Reset flushes the pipeline
   a_flush: assert property (@(posedge clock)
      $past(reset, 1) |-> !rsp_valid)
      else $error("result strobe right after reset");

endmodule

bind hex_pixel_to_cell_round hpc_checker u_hpc_checker (.*);

### dv/tb_hex_pixel_to_cell_round.sv
// Self-checking testbench for the hex pixel-to-cell rounding pipeline.
module tb_hex_pixel_to_cell_round;
   timeunit 1ns;
   timeprecision 1ps;

   import hpc_pkg::*;

   localparam int FRAC        = FRAC_BITS_DEFAULT;
   localparam int LATENCY     = 5;
   localparam int CYCLE_LIMIT = 200000;
   localparam int PHASES      = 6;
   localparam int PHASE_ITEMS = 160;
   localparam int N_DIRECTED  = 20;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   req_type     req_data;
   logic        rsp_valid;
   rsp_type     rsp_data;
   logic        csr_we;
   logic [15:0] csr_wdata;

   // Reciprocal as last written, and cells still owed by the pipeline
   logic [15:0] recip_now;
   rsp_type     expected_cells[$];

   int cycle_count = 0;
   int mismatches  = 0;
   int transfers   = 0;
   int compared    = 0;
   int recip_writes = 0;
   int burst_left  = 0;

   typedef struct {
      logic [15:0] recip;
      req_type     pixel;
      bit          typed;
      rsp_type     answer;
   } stim_row;

   // Directed rows: extremes, alternating bits, zero reciprocal and a half-way rounding
   stim_row directed_rows [N_DIRECTED] = '{
      '{16'd1024,  '{16'h0000, 16'h0000}, 1'b1, '{16'h0000, 16'h0000}},
      '{16'd1024,  '{16'h7FFF, 16'h7FFF}, 1'b0, '{16'h0000, 16'h0000}},
      '{16'd1024,  '{16'h8000, 16'h8000}, 1'b0, '{16'h0000, 16'h0000}},
      '{16'd1024,  '{16'h7FFF, 16'h8000}, 1'b0, '{16'h0000, 16'h0000}},
      '{16'd1024,  '{16'h8000, 16'h7FFF}, 1'b0, '{16'h0000, 16'h0000}},
      '{16'd1024,  '{16'h0010, 16'h0000}, 1'b0, '{16'h0000, 16'h0000}},
      '{16'd1024,  '{16'h0000, 16'h0040}, 1'b0, '{16'h0000, 16'h0000}},
      '{16'd1024,  '{16'hFFF0, 16'hFFF0}, 1'b0, '{16'h0000, 16'h0000}},
      '{16'd1024,  '{16'h5555, 16'hAAAA}, 1'b0, '{16'h0000, 16'h0000}},
      '{16'd1024,  '{16'hAAAA, 16'h5555}, 1'b0, '{16'h0000, 16'h0000}},
      '{16'd0,     '{16'h7FFF, 16'h7FFF}, 1'b1, '{16'h0000, 16'h0000}},
      '{16'd0,     '{16'h8000, 16'h8000}, 1'b1, '{16'h0000, 16'h0000}},
      '{16'd0,     '{16'h1234, 16'hEDCB}, 1'b1, '{16'h0000, 16'h0000}},
      '{16'hFFFF,  '{16'h7FFF, 16'h8000}, 1'b0, '{16'h0000, 16'h0000}},
      '{16'hFFFF,  '{16'h8000, 16'h7FFF}, 1'b0, '{16'h0000, 16'h0000}},
      '{16'hFFFF,  '{16'h7FFF, 16'h7FFF}, 1'b0, '{16'h0000, 16'h0000}},
      '{16'hFFFF,  '{16'hFFFF, 16'h0001}, 1'b0, '{16'h0000, 16'h0000}},
      '{16'd1,     '{16'h7FFF, 16'h7FFF}, 1'b0, '{16'h0000, 16'h0000}},
      '{16'd1,     '{16'h8000, 16'h8000}, 1'b0, '{16'h0000, 16'h0000}},
      '{16'd1,     '{16'h0001, 16'hFFFF}, 1'b0, '{16'h0000, 16'h0000}}
   };

   hex_pixel_to_cell_round #(
      .FRAC_BITS(FRAC)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data),
      .csr_we   (csr_we),
      .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Round a Q16 value to the nearest integer, half away from zero
   function automatic longint round_half_away(longint v);
      longint half;
      longint one;
      half = longint'(1) << (Q_BITS - 1);
      one  = longint'(1) << Q_BITS;
      if (v >= 0) begin
         return (v + half) / one;
      end
      return -((-v + half) / one);
   endfunction

   function automatic longint abs_q(longint v);
      return (v < 0) ? -v : v;
   endfunction

   function automatic logic signed [15:0] clamp_coord(longint v);
      if (v > 32767) begin
         return 16'sh7FFF;
      end
      if (v < -32768) begin
         return 16'sh8000;
      end
      return v[15:0];
   endfunction

   // Invert the hex basis, then cube-round and rebuild the worst component
   function automatic rsp_type predict_cell(req_type pix, logic [15:0] recip);
      longint px, py, r, ay, ax, fx, fy, fz;
      longint rx, ry, rz, ex, ey, ez, one;
      rsp_type cell_out;
      one = longint'(1) << Q_BITS;
      px  = pix.pixel_x;
      py  = pix.pixel_y;
      r   = longint'(recip);
      ay  = longint'(K_Y_FROM_X) * px - longint'(K_EIGHT) * py;
      ax  = longint'(K_X_FROM_Y) * py - longint'(K_FOUR) * px;
      // floor of the scaled sums, kept as Q16
      fy  = (ay * r) >>> (FRAC + Q_BITS);
      fx  = (ax * r) >>> (FRAC + Q_BITS);
      fz  = -fx - fy;
      rx  = round_half_away(fx);
      ry  = round_half_away(fy);
      rz  = round_half_away(fz);
      ex  = abs_q(rx * one - fx);
      ey  = abs_q(ry * one - fy);
      ez  = abs_q(rz * one - fz);
      // rebuild the component that rounded worst; a tie with z keeps the rounded values, an x-y tie rebuilds y
      if (ex > ey && ex > ez) begin
         rx = -ry - rz;
      end else if (ey > ez) begin
         ry = -rx - rz;
      end
      cell_out.cell_x = clamp_coord(rx);
      cell_out.cell_y = clamp_coord(ry);
      return cell_out;
   endfunction

   // One pixel coordinate: full range, near zero, mid range or an edge value
   function automatic logic [15:0] pick_coord();
      logic [15:0] edges [7];
      edges = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001, 16'h8001, 16'h7FFE};
      case ($urandom_range(0, 3))
         0: begin
            return 16'($urandom);
         end
         1: begin
            return 16'($urandom_range(0, 2047) - 1024);
         end
         2: begin
            return edges[$urandom_range(0, 6)];
         end
         default: begin
            return 16'($urandom_range(0, 32767) - 16384);
         end
      endcase
   endfunction

   // Drop start and keep it low; n sets the length of the idle gap
   task automatic hold_idle(input int n);
      @(negedge clock);
      start <= 1'b0;
      repeat (n - 1) @(negedge clock);
   endtask

   // Wait for every owed cell, then let the pipeline settle
   task automatic wait_drained();
      while (expected_cells.size() != 0) @(posedge clock);
      repeat (LATENCY + 2) @(negedge clock);
   endtask

   task automatic write_recip(input logic [15:0] value);
      hold_idle(1);
      wait_drained();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
      recip_now = value;
      recip_writes++;
   endtask

   // Present one pixel and record the cell it must produce once transferred
   task automatic send_pixel(input req_type pix, input bit typed, input rsp_type answer);
      if (burst_left == 0) begin
         if ($urandom_range(0, 3) != 0) begin
            hold_idle($urandom_range(1, 6));
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      @(negedge clock);
      start    <= 1'b1;
      req_data <= pix;
      do @(posedge clock); while (busy);
      expected_cells.push_back(typed ? answer : predict_cell(pix, recip_now));
      transfers++;
   endtask

   // Check each result against the oldest owed cell
   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (expected_cells.size() == 0) begin
            $error("unexpected result: cell_x %0d cell_y %0d",
                   rsp_data.cell_x, rsp_data.cell_y);
            mismatches++;
         end else begin
            want = expected_cells.pop_front();
            compared++;
            if (rsp_data.cell_x !== want.cell_x) begin
               $error("cell_x mismatch: expected %0d, got %0d", want.cell_x, rsp_data.cell_x);
               mismatches++;
            end
            if (rsp_data.cell_y !== want.cell_y) begin
               $error("cell_y mismatch: expected %0d, got %0d", want.cell_y, rsp_data.cell_y);
               mismatches++;
            end
         end
      end
   end

   // Bound the run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_hex_pixel_to_cell_round: errors");
         $finish;
      end
   end

   initial begin : stimulus
      logic [15:0] phase_recip [PHASES];
      req_type     pix;
      rsp_type     none;

      reset     <= 1'b1;
      start     <= 1'b0;
      req_data  <= '0;
      csr_we    <= 1'b0;
      csr_wdata <= '0;
      recip_now = RECIP_RESET;
      none      = '0;
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // Directed table; rewrite the reciprocal whenever a row asks for another
      for (int i = 0; i < N_DIRECTED; i++) begin
         if (directed_rows[i].recip != recip_now) begin
            write_recip(directed_rows[i].recip);
         end
         send_pixel(directed_rows[i].pixel, directed_rows[i].typed, directed_rows[i].answer);
      end

      // Random phases, one reciprocal each
      phase_recip = '{16'd4096, 16'hFFFF, 16'd1, 16'($urandom_range(1, 65535)),
                      16'd16384, 16'($urandom_range(2, 65534))};
      for (int p = 0; p < PHASES; p++) begin
         write_recip(phase_recip[p]);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // hold the sender once until the pipeline is empty
            if (p == 1 && n == PHASE_ITEMS / 2) begin
               hold_idle(1);
               wait_drained();
            end
            pix.pixel_x = pick_coord();
            pix.pixel_y = pick_coord();
            send_pixel(pix, 1'b0, none);
         end
      end

      hold_idle(1);
      wait_drained();

      $display("covered %0d pixel transfers over %0d reciprocal writes, incl. zero and full scale",
               transfers, recip_writes);
      $display("compared %0d cells, %0d mismatches", compared, mismatches);
      if (mismatches == 0 && expected_cells.size() == 0) begin
         $display("tb_hex_pixel_to_cell_round: clean");
      end else begin
         $display("tb_hex_pixel_to_cell_round: errors");
      end
      $finish;
   end

endmodule

### hex_pixel_to_cell_round.f
hw/rtl/hpc_pkg.sv
hw/rtl/hpc_cube_round.sv
hw/rtl/hex_pixel_to_cell_round.sv
hw/rtl/hpc_checker.sv
dv/tb_hex_pixel_to_cell_round.sv
